### hw/rtl/aodf_pkg.sv
// Shared types and codes for the age-ordered dual-class queue.
`timescale 1ns / 1ps

package aodf_pkg;

  // Request codes on in_operation
  localparam logic [1:0] OP_ENQUEUE        = 2'd0;
  localparam logic [1:0] OP_DEQUEUE        = 2'd1;
  localparam logic [1:0] OP_DEQUEUE_OLDEST = 2'd2;

  // Result codes on out_status
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Arrival stamp width
  localparam int STAMP_BITS = 8;

  // Request sequencer
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } aodf_state_t;

endpackage

### hw/rtl/age_ordered_dual_fifo.sv
// Top level: two class queues in block memories with a shared arrival stamp.
`timescale 1ns / 1ps

//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+--------------------------
//  request  | in_operation, in_item_class, in_payload      | start high, busy low
//  result   | out_status, out_class, out_payload,          | out_valid, one cycle,
//           | out_all_empty, out_first/second_class_empty  | no back-pressure
//
// For each request, the accept edge reads both head entries from the
// class memories into registers; the next cycle decides, writes the
// tail entry, moves the pointers and registers the result word.
// out_valid rises the cycle after that, and busy is already low then.
// rst_n clears pointers, stamp counter and sequencer; no memory clear.
// The receiver cannot stall; each result word stands for exactly one cycle.
module age_ordered_dual_fifo #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic        in_item_class,
  input  logic [15:0] in_payload,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_class,
  output logic [15:0] out_payload,
  output logic        out_all_empty,
  output logic        out_first_class_empty,
  output logic        out_second_class_empty
);
  import aodf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int EW = PAYLOAD_BITS + STAMP_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  // Advance a pointer: index wraps at DEPTH, top bit counts laps
  function automatic logic [AW:0] ptr_inc(input logic [AW:0] p);
    logic [AW:0] r;
    if (p[AW-1:0] == LAST_IDX) begin
      r = {~p[AW], {AW{1'b0}}};
    end else begin
      r = {p[AW], p[AW-1:0] + AW'(1)};
    end
    return r;
  endfunction

  aodf_state_t state_r, state_nxt;

  logic [AW:0] h0_r, t0_r, h1_r, t1_r;
  logic [AW:0] h0_nxt, t0_nxt, h1_nxt, t1_nxt;
  logic [STAMP_BITS-1:0] cnt_r, cnt_nxt;

  logic [1:0]              op_r;
  logic                    cls_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [EW-1:0]           rd0_r, rd1_r;

  logic [EW-1:0] mem0 [DEPTH];
  logic [EW-1:0] mem1 [DEPTH];

  logic                    acc;
  logic                    exec;
  logic [PAYLOAD_BITS-1:0] pay_in_w;
  logic [PAYLOAD_BITS-1:0] sel_pay;
  logic [15:0]             pay_out_w;
  logic                    emp0, emp1, full0, full1;
  logic [STAMP_BITS-1:0]   stamp_diff;
  logic [1:0]              status_w;
  logic                    take, pick, enq0, enq1;
  logic                    pop0, pop1;

  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic                    out_class_r;
  logic [15:0]             out_payload_r;
  logic                    emp0_out_r, emp1_out_r;

  assign acc  = start && !busy;
  assign exec = (state_r == ST_EXEC);

  // Fit the payload to the stored width and back to the port width
  if (PAYLOAD_BITS >= 16) begin : g_wide
    assign pay_in_w  = PAYLOAD_BITS'(in_payload);
    assign pay_out_w = sel_pay[15:0];
  end else begin : g_narrow
    assign pay_in_w  = in_payload[PAYLOAD_BITS-1:0];
    assign pay_out_w = 16'(sel_pay);
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and busy
  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Latch the request word
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r  <= in_operation;
      cls_r <= in_item_class;
      pay_r <= pay_in_w;
    end
  end

  // Class 0 memory: write at tail, read head on accept
  always_ff @(posedge clk) begin
    if (exec && enq0) begin
      mem0[t0_r[AW-1:0]] <= {cnt_r, pay_r};
    end
    if (acc) begin
      rd0_r <= mem0[h0_r[AW-1:0]];
    end
  end

  // Class 1 memory: write at tail, read head on accept
  always_ff @(posedge clk) begin
    if (exec && enq1) begin
      mem1[t1_r[AW-1:0]] <= {cnt_r, pay_r};
    end
    if (acc) begin
      rd1_r <= mem1[h1_r[AW-1:0]];
    end
  end

  // Fill state from the pointers
  assign emp0  = (h0_r == t0_r);
  assign emp1  = (h1_r == t1_r);
  assign full0 = (h0_r[AW] != t0_r[AW]) && (h0_r[AW-1:0] == t0_r[AW-1:0]);
  assign full1 = (h1_r[AW] != t1_r[AW]) && (h1_r[AW-1:0] == t1_r[AW-1:0]);

  // Class 0 head is older when the wrapped stamp difference is negative
  assign stamp_diff = rd0_r[EW-1 -: STAMP_BITS] - rd1_r[EW-1 -: STAMP_BITS];

  // Decide the request
  always_comb begin
    status_w = STATUS_OK;
    take     = 1'b0;
    pick     = cls_r;
    enq0     = 1'b0;
    enq1     = 1'b0;
    case (op_r)
      OP_ENQUEUE: begin
        if (cls_r ? full1 : full0) begin
          status_w = STATUS_FULL;
        end else begin
          enq0 = !cls_r;
          enq1 = cls_r;
        end
      end
      OP_DEQUEUE: begin
        if (cls_r ? emp1 : emp0) begin
          status_w = STATUS_EMPTY;
        end else begin
          take = 1'b1;
        end
      end
      OP_DEQUEUE_OLDEST: begin
        if (emp0 && emp1) begin
          status_w = STATUS_EMPTY;
        end else begin
          take = 1'b1;
          if (emp0) begin
            pick = 1'b1;
          end else if (emp1) begin
            pick = 1'b0;
          end else begin
            pick = !stamp_diff[STAMP_BITS-1];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign pop0    = take && !pick;
  assign pop1    = take && pick;
  assign sel_pay = pick ? rd1_r[PAYLOAD_BITS-1:0] : rd0_r[PAYLOAD_BITS-1:0];

  // Pointer and stamp updates
  assign h0_nxt  = pop0 ? ptr_inc(h0_r) : h0_r;
  assign h1_nxt  = pop1 ? ptr_inc(h1_r) : h1_r;
  assign t0_nxt  = enq0 ? ptr_inc(t0_r) : t0_r;
  assign t1_nxt  = enq1 ? ptr_inc(t1_r) : t1_r;
  assign cnt_nxt = (enq0 || enq1) ? cnt_r + STAMP_BITS'(1) : cnt_r;

  // Commit pointers at the end of the decide cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h0_r  <= '0;
      t0_r  <= '0;
      h1_r  <= '0;
      t1_r  <= '0;
      cnt_r <= '0;
    end else if (exec) begin
      h0_r  <= h0_nxt;
      t0_r  <= t0_nxt;
      h1_r  <= h1_nxt;
      t1_r  <= t1_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (exec) begin
      out_status_r  <= status_w;
      out_class_r   <= take ? pick : 1'b0;
      out_payload_r <= take ? pay_out_w : 16'd0;
      emp0_out_r    <= (h0_nxt == t0_nxt);
      emp1_out_r    <= (h1_nxt == t1_nxt);
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_class              = out_class_r;
  assign out_payload            = out_payload_r;
  assign out_first_class_empty  = emp0_out_r;
  assign out_second_class_empty = emp1_out_r;
  assign out_all_empty          = emp0_out_r && emp1_out_r;

  // Every accepted request is followed by its result word
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("result word missing after accepted request");

  // A result word never overlaps a request in progress
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word while busy");

  // A queue is never both empty and full
  a_fill_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(emp0 && full0) && !(emp1 && full1))
    else $error("queue pointers inconsistent");

  // A full report means the queues are not both empty
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> !out_all_empty)
    else $error("full status with both queues empty");

endmodule

### tb/sv/tb_age_ordered_dual_fifo.sv
// Testbench for the age-ordered dual-class queue with a queue-level result prediction.
`timescale 1ns / 1ps

module tb_age_ordered_dual_fifo;
  import aodf_pkg::*;

  localparam int          FIFO_DEPTH     = 16;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  typedef struct packed {
    logic [STAMP_BITS-1:0] stamp;
    logic [15:0]           id;
  } class_entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        cls;
    logic [15:0] payload;
    logic        all_empty;
    logic        first_empty;
    logic        second_empty;
  } queue_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = OP_ENQUEUE;
  logic        in_item_class = 1'b0;
  logic [15:0] in_payload = 16'h0000;
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_class;
  logic [15:0] out_payload;
  logic        out_all_empty;
  logic        out_first_class_empty;
  logic        out_second_class_empty;

  // Predicted contents of both class queues and the shared stamp
  class_entry_t          first_fifo[$];
  class_entry_t          second_fifo[$];
  logic [STAMP_BITS-1:0] arrival_stamp = '0;

  queue_result_t queue_results_due[$];
  int            fail_count = 0;
  int            quiet_cycles = 0;
  int            idle_pct = 0;

  age_ordered_dual_fifo #(
    .DEPTH        (FIFO_DEPTH),
    .PAYLOAD_BITS (16)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_operation           (in_operation),
    .in_item_class          (in_item_class),
    .in_payload             (in_payload),
    .out_valid              (out_valid),
    .out_status             (out_status),
    .out_class              (out_class),
    .out_payload            (out_payload),
    .out_all_empty          (out_all_empty),
    .out_first_class_empty  (out_first_class_empty),
    .out_second_class_empty (out_second_class_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the predicted queues and return the result word it causes
  function automatic queue_result_t compute_queue_result(input logic [1:0] op,
                                                         input logic cls,
                                                         input logic [15:0] pay);
    queue_result_t         r;
    class_entry_t          e;
    logic                  found;
    logic                  take_first;
    logic [STAMP_BITS-1:0] diff;
    r = '0;
    found = 1'b1;
    take_first = 1'b0;
    if (op == OP_ENQUEUE) begin
      if ((cls ? second_fifo.size() : first_fifo.size()) >= FIFO_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        e.stamp = arrival_stamp;
        e.id = pay;
        if (cls) second_fifo = {second_fifo, e};
        else first_fifo = {first_fifo, e};
        arrival_stamp = arrival_stamp + STAMP_BITS'(1);
      end
    end else if (op == OP_DEQUEUE || op == OP_DEQUEUE_OLDEST) begin
      if (op == OP_DEQUEUE) begin
        take_first = !cls;
        found = cls ? (second_fifo.size() != 0) : (first_fifo.size() != 0);
      end else if (first_fifo.size() == 0) begin
        found = (second_fifo.size() != 0);
      end else if (second_fifo.size() == 0) begin
        take_first = 1'b1;
      end else begin
        // Class 0 wins only when strictly older, modulo the stamp width
        diff = first_fifo[0].stamp - second_fifo[0].stamp;
        take_first = diff[STAMP_BITS-1];
      end
      if (!found) begin
        r.status = STATUS_EMPTY;
      end else if (take_first) begin
        e = first_fifo[0];
        first_fifo.delete(0);
        r.payload = e.id;
      end else begin
        e = second_fifo[0];
        second_fifo.delete(0);
        r.cls = 1'b1;
        r.payload = e.id;
      end
    end
    r.first_empty = (first_fifo.size() == 0);
    r.second_empty = (second_fifo.size() == 0);
    r.all_empty = r.first_empty && r.second_empty;
    return r;
  endfunction

  // Present one request word, hold it until accepted, then log its expected result
  task automatic send_request(input logic [1:0] op, input logic cls, input logic [15:0] pay);
    queue_result_t r;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_item_class <= cls;
    in_payload <= pay;
    do @(posedge clk); while (busy);
    r = compute_queue_result(op, cls, pay);
    queue_results_due = {queue_results_due, r};
  endtask

  // Empty both classes through oldest-first dequeues
  task automatic drain_queues();
    while (first_fifo.size() + second_fifo.size() != 0)
      send_request(OP_DEQUEUE_OLDEST, 1'($urandom_range(1)), 16'($urandom));
  endtask

  // Empty requests, unused code, payload extremes, oldest with one class empty
  task automatic test_edge_requests();
    send_request(OP_DEQUEUE, 1'b0, 16'hFFFF);
    send_request(OP_DEQUEUE, 1'b1, 16'h0000);
    send_request(OP_DEQUEUE_OLDEST, 1'b0, 16'h0000);
    send_request(OP_UNUSED, 1'b1, 16'hFFFF);
    send_request(OP_ENQUEUE, 1'b0, 16'h0000);
    send_request(OP_ENQUEUE, 1'b1, 16'hFFFF);
    send_request(OP_ENQUEUE, 1'b0, 16'hAAAA);
    send_request(OP_ENQUEUE, 1'b1, 16'h5555);
    send_request(OP_UNUSED, 1'b0, 16'h1234);
    send_request(OP_DEQUEUE_OLDEST, 1'b1, 16'h0000);
    send_request(OP_DEQUEUE_OLDEST, 1'b0, 16'h0000);
    send_request(OP_DEQUEUE, 1'b1, 16'h0000);
    send_request(OP_DEQUEUE_OLDEST, 1'b1, 16'h0000);
    send_request(OP_DEQUEUE_OLDEST, 1'b0, 16'h0000);
    send_request(OP_ENQUEUE, 1'b1, 16'h8001);
    send_request(OP_DEQUEUE_OLDEST, 1'b0, 16'h0000);
    send_request(OP_DEQUEUE, 1'b0, 16'h0000);
  endtask

  // Fill both classes past their depth so the extra words are dropped, then drain past empty
  task automatic test_class_full();
    drain_queues();
    send_request(OP_ENQUEUE, 1'b0, 16'h0F0F);
    for (int i = 0; i <= FIFO_DEPTH; i++)
      send_request(OP_ENQUEUE, 1'b1, 16'($urandom));
    for (int i = 0; i <= FIFO_DEPTH; i++)
      send_request(OP_ENQUEUE, 1'b0, 16'($urandom));
    for (int i = 0; i <= FIFO_DEPTH; i++)
      send_request(OP_DEQUEUE, 1'b1, 16'($urandom));
    drain_queues();
  endtask

  // Cycle class 1 until its new head carries the same stamp as the class 0 head
  task automatic test_equal_stamps();
    drain_queues();
    send_request(OP_ENQUEUE, 1'b0, 16'hC0DE);
    for (int i = 0; i < (1 << STAMP_BITS) - 1; i++) begin
      send_request(OP_ENQUEUE, 1'b1, 16'($urandom));
      send_request(OP_DEQUEUE, 1'b1, 16'($urandom));
    end
    send_request(OP_ENQUEUE, 1'b1, 16'hBEEF);
    send_request(OP_DEQUEUE_OLDEST, 1'b0, 16'h0000);
    send_request(OP_DEQUEUE_OLDEST, 1'b0, 16'h0000);
  endtask

  // Random traffic in bursts whose enqueue bias swings between filling and draining
  task automatic test_random_traffic(input int n_items, input int sender_idle);
    int          enq_bias;
    int          pick;
    logic [15:0] pay;
    idle_pct = sender_idle;
    enq_bias = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0: enq_bias = 15;
          1: enq_bias = 50;
          default: enq_bias = 85;
        endcase
      end
      case ($urandom_range(15))
        0: pay = 16'h0000;
        1: pay = 16'hFFFF;
        default: pay = 16'($urandom);
      endcase
      pick = $urandom_range(99);
      if (pick < enq_bias) send_request(OP_ENQUEUE, 1'($urandom_range(1)), pay);
      else if (pick < enq_bias + (100 - enq_bias) * 45 / 100)
        send_request(OP_DEQUEUE, 1'($urandom_range(1)), pay);
      else if (pick < enq_bias + (100 - enq_bias) * 90 / 100)
        send_request(OP_DEQUEUE_OLDEST, 1'($urandom_range(1)), pay);
      else send_request(OP_UNUSED, 1'($urandom_range(1)), pay);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] expv,
                             input logic [15:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      fail_count++;
    end
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    queue_result_t exp_r;
    if (rst_n && out_valid) begin
      if (queue_results_due.size() == 0) begin
        $error("result word with no request outstanding");
        fail_count++;
      end else begin
        exp_r = queue_results_due[0];
        queue_results_due.delete(0);
        check_field("status", 16'(exp_r.status), 16'(out_status));
        check_field("out_class", 16'(exp_r.cls), 16'(out_class));
        check_field("out_payload", exp_r.payload, out_payload);
        check_field("all_empty", 16'(exp_r.all_empty), 16'(out_all_empty));
        check_field("first_class_empty", 16'(exp_r.first_empty),
                    16'(out_first_class_empty));
        check_field("second_class_empty", 16'(exp_r.second_empty),
                    16'(out_second_class_empty));
      end
    end
  end

  // End the run when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_requests();
    test_class_full();
    test_equal_stamps();
    test_random_traffic(400, 25);
    test_random_traffic(400, 73);
    test_random_traffic(400, 0);
    start <= 1'b0;
    while (queue_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
